/* rtl/core/vec3_vector_alu_core_defines.svh */
// assertion macros for the vector alu core
`ifndef VEC3_VECTOR_ALU_CORE_DEFINES_SVH
`define VEC3_VECTOR_ALU_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define V3ALU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vector alu assertion failed");

// next-cycle implication, checked out of reset
`define V3ALU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vector alu assertion failed");

`endif

/* rtl/core/v3alu_pkg.sv */
// ----------------------------------------------------------------------------
// v3alu_pkg
// Shared constants and opcode type of the three-component vector alu.
// ----------------------------------------------------------------------------
package v3alu_pkg;

  localparam int COMP_WIDTH_DEF    = 16;
  localparam int LEN_FRAC_BITS_DEF = 8;
  localparam int VEC_W             = 32;
  localparam int SCALAR_W          = 33;
  localparam int OP_W              = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 3'd0,
    OP_NEG   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DOT   = 3'd3,
    OP_CROSS = 3'd4,
    OP_LEN   = 3'd5
  } op_t;

endpackage

/* rtl/core/v3alu_if.sv */
// ----------------------------------------------------------------------------
// v3alu_in_if / v3alu_out_if
// Valid/ready channels carrying the operand word and the result word.
// ----------------------------------------------------------------------------
interface v3alu_in_if #(
  parameter int CW = v3alu_pkg::COMP_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic [v3alu_pkg::OP_W-1:0]  opcode;
  logic signed [CW-1:0]        a_x;
  logic signed [CW-1:0]        a_y;
  logic signed [CW-1:0]        a_z;
  logic signed [CW-1:0]        b_x;
  logic signed [CW-1:0]        b_y;
  logic signed [CW-1:0]        b_z;

  modport source (output valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink   (input valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface v3alu_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [v3alu_pkg::VEC_W-1:0]    r_x;
  logic signed [v3alu_pkg::VEC_W-1:0]    r_y;
  logic signed [v3alu_pkg::VEC_W-1:0]    r_z;
  logic signed [v3alu_pkg::SCALAR_W-1:0] scalar_out;

  modport source (output valid, r_x, r_y, r_z, scalar_out, input ready);
  modport sink   (input valid, r_x, r_y, r_z, scalar_out, output ready);
endinterface

/* rtl/core/v3alu_lane.sv */
// ----------------------------------------------------------------------------
// v3alu_lane
// One component lane: two products and an add/negate, registered.
// ----------------------------------------------------------------------------
module v3alu_lane #(
  parameter int CW = v3alu_pkg::COMP_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  v3alu_pkg::op_t       op,
  input  logic signed [CW-1:0] a_i,
  input  logic signed [CW-1:0] a_j,
  input  logic signed [CW-1:0] a_k,
  input  logic signed [CW-1:0] b_i,
  input  logic signed [CW-1:0] b_j,
  input  logic signed [CW-1:0] b_k,
  input  logic signed [CW-1:0] b_x,
  output logic signed [2*CW-1:0] p0_r,
  output logic signed [2*CW-1:0] p1_r,
  output logic signed [CW:0]     sum_r
);

  logic signed [CW-1:0]   m0;
  logic signed [CW-1:0]   m1;
  logic signed [CW:0]     sum_nxt;
  logic signed [2*CW-1:0] p0_nxt;
  logic signed [2*CW-1:0] p1_nxt;

  always_comb begin
    case (op)
      v3alu_pkg::OP_SCALE: begin m0 = a_i; m1 = b_x; end
      v3alu_pkg::OP_CROSS: begin m0 = a_j; m1 = b_k; end
      v3alu_pkg::OP_LEN:   begin m0 = a_i; m1 = a_i; end
      default:             begin m0 = a_i; m1 = b_i; end
    endcase
    if (op == v3alu_pkg::OP_NEG) begin
      sum_nxt = -(CW+1)'(a_i);
    end else begin
      sum_nxt = (CW+1)'(a_i) + (CW+1)'(b_i);
    end
    p0_nxt = m0 * m1;
    // cross subtrahend a_k*b_j
    p1_nxt = a_k * b_j;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

/* rtl/core/v3alu_sqrt_stage.sv */
// ----------------------------------------------------------------------------
// v3alu_sqrt_stage
// One digit of the restoring square root: one bit pair in, one root bit out.
// ----------------------------------------------------------------------------
module v3alu_sqrt_stage #(
  parameter int RW = v3alu_pkg::COMP_WIDTH_DEF + v3alu_pkg::LEN_FRAC_BITS_DEF,
  parameter int XW = 2 * RW
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW+1:0] rem_in,
  input  logic [RW-1:0] root_in,
  input  logic [XW-1:0] x_in,
  output logic [RW+1:0] rem_r,
  output logic [RW-1:0] root_r,
  output logic [XW-1:0] x_r
);

  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic          ge;
  logic [RW+1:0] rem_nxt;
  logic [RW-1:0] root_nxt;
  logic [XW-1:0] x_nxt;

  always_comb begin
    rem_sh   = {rem_in[RW-1:0], x_in[XW-1:XW-2]};
    trial    = {root_in, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    // top root bit is still zero before the last digit
    root_nxt = {root_in[RW-2:0], ge};
    x_nxt    = x_in << 2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      x_r    <= x_nxt;
    end
  end

endmodule

/* rtl/core/vec3_vector_alu_core.sv */
// Three-component integer vector alu: add, negate, scale by b_x, dot, cross and
// length (floor of sqrt of the squared norm, with LEN_FRAC_BITS fraction bits).
// One word is accepted every cycle unless the pipeline is held. The result passes the
// lane registers, the merge register and a pipelined square root that takes one
// root bit per stage. The whole pipeline holds when the output word is not taken.
// ----------------------------------------------------------------------------
// vec3_vector_alu_core
// Three product lanes, a merge stage, a square-root pipeline and the result word.
// ----------------------------------------------------------------------------
`include "vec3_vector_alu_core_defines.svh"

module vec3_vector_alu_core #(
  parameter int COMP_WIDTH    = v3alu_pkg::COMP_WIDTH_DEF,
  parameter int LEN_FRAC_BITS = v3alu_pkg::LEN_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  v3alu_in_if.sink    in_ch,
  v3alu_out_if.source out_ch
);

  localparam int CW = COMP_WIDTH;
  localparam int RW = COMP_WIDTH + LEN_FRAC_BITS;
  localparam int XW = 2 * RW;
  localparam int NS = RW;
  localparam int WW = (2*CW+2 > 34) ? 2*CW+2 : 34;
  localparam int VW = v3alu_pkg::VEC_W;
  localparam int SW = v3alu_pkg::SCALAR_W;

  logic                  en;
  v3alu_pkg::op_t        in_op;
  v3alu_pkg::op_t        op0_r;
  logic                  v0_r;

  logic signed [2*CW-1:0] p0 [3];
  logic signed [2*CW-1:0] p1 [3];
  logic signed [CW:0]     sm [3];
  logic signed [CW-1:0]   av [3];
  logic signed [CW-1:0]   bv [3];

  logic signed [WW-1:0]  lv [3];
  logic signed [WW-1:0]  dot;
  logic [XW-1:0]         x_init;

  // stage 0 is the merge output, stage k the output of sqrt digit k
  logic                  v_r    [NS+1];
  v3alu_pkg::op_t        op_r   [NS+1];
  logic signed [VW-1:0]  vec_r  [NS+1][3];
  logic signed [SW-1:0]  dot_r  [NS+1];
  logic [RW+1:0]         rem_w  [NS+1];
  logic [RW-1:0]         root_w [NS+1];
  logic [XW-1:0]         x_w    [NS+1];

  assign en          = !v_r[NS] || out_ch.ready;
  assign in_ch.ready = en;
  assign in_op       = v3alu_pkg::op_t'(in_ch.opcode);

  assign av[0] = in_ch.a_x; assign av[1] = in_ch.a_y; assign av[2] = in_ch.a_z;
  assign bv[0] = in_ch.b_x; assign bv[1] = in_ch.b_y; assign bv[2] = in_ch.b_z;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3alu_lane #(.CW(CW)) u_lane (
      .clk   (clk),
      .en    (en),
      .op    (in_op),
      .a_i   (av[i]),
      .a_j   (av[(i+1)%3]),
      .a_k   (av[(i+2)%3]),
      .b_i   (bv[i]),
      .b_j   (bv[(i+1)%3]),
      .b_k   (bv[(i+2)%3]),
      .b_x   (bv[0]),
      .p0_r  (p0[i]),
      .p1_r  (p1[i]),
      .sum_r (sm[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0_r <= in_op;
    end
  end

  // merge: combine lane products and sums into vector and scalar results
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (op0_r) inside
        v3alu_pkg::OP_ADD,
        v3alu_pkg::OP_NEG:   lv[i] = WW'(sm[i]);
        v3alu_pkg::OP_SCALE: lv[i] = WW'(p0[i]);
        v3alu_pkg::OP_CROSS: lv[i] = WW'(p0[i]) - WW'(p1[i]);
        default:             lv[i] = '0;
      endcase
    end
    dot    = WW'(p0[0]) + WW'(p0[1]) + WW'(p0[2]);
    // squares sum is nonnegative and below 2^(2*CW)
    x_init = XW'(dot[2*CW-1:0]) << (2*LEN_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r[0] <= op0_r;
      for (int i = 0; i < 3; i++) begin
        vec_r[0][i] <= lv[i][VW-1:0];
      end
      dot_r[0]  <= (op0_r == v3alu_pkg::OP_DOT) ? dot[SW-1:0] : '0;
      rem_w[0]  <= '0;
      root_w[0] <= '0;
      x_w[0]    <= x_init;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_sqrt
    v3alu_sqrt_stage #(.RW(RW), .XW(XW)) u_stage (
      .clk     (clk),
      .en      (en),
      .rem_in  (rem_w[k-1]),
      .root_in (root_w[k-1]),
      .x_in    (x_w[k-1]),
      .rem_r   (rem_w[k]),
      .root_r  (root_w[k]),
      .x_r     (x_w[k])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        op_r[k]  <= op_r[k-1];
        vec_r[k] <= vec_r[k-1];
        dot_r[k] <= dot_r[k-1];
      end
    end
  end

  assign out_ch.valid      = v_r[NS];
  assign out_ch.r_x        = vec_r[NS][0];
  assign out_ch.r_y        = vec_r[NS][1];
  assign out_ch.r_z        = vec_r[NS][2];
  assign out_ch.scalar_out = (op_r[NS] == v3alu_pkg::OP_LEN) ? SW'(root_w[NS]) : dot_r[NS];

  `V3ALU_ASSERT_IMP(a_vec_zero_scalar_op,
    v_r[NS] && (op_r[NS] == v3alu_pkg::OP_DOT || op_r[NS] == v3alu_pkg::OP_LEN),
    vec_r[NS][0] == '0 && vec_r[NS][1] == '0 && vec_r[NS][2] == '0)
  `V3ALU_ASSERT_IMP(a_scalar_zero_vec_op,
    v_r[NS] && op_r[NS] != v3alu_pkg::OP_DOT && op_r[NS] != v3alu_pkg::OP_LEN,
    out_ch.scalar_out == '0)
  `V3ALU_ASSERT_IMP(a_stall_only_when_blocked,
    !in_ch.ready, out_ch.valid && !out_ch.ready)
  `V3ALU_ASSERT_NXT(a_stalled_result_holds,
    out_ch.valid && !out_ch.ready, out_ch.valid && $stable(op_r[NS]))

endmodule
